>>> design/emergency_flag_aggregator_assert.svh
// Assertion macros used by the aggregator back end (efa_back).
// They expect clk and arst_n in scope.
`ifndef EMERGENCY_FLAG_AGGREGATOR_ASSERT_SVH
`define EMERGENCY_FLAG_AGGREGATOR_ASSERT_SVH

`define EFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define EFA_NEVER(lbl, cond, msg) \
	`EFA_ASSERT(lbl, !(cond), msg)

`endif

>>> design/efa_pkg.sv
package efa_pkg;

	localparam int unsigned IN_DATA_W   = 32;
	localparam int unsigned IN_USER_W   = 2;
	localparam int unsigned OUT_DATA_W  = 16;
	localparam int unsigned NODE_IDX_W  = 4;
	localparam int unsigned EXC_IN_W    = 8;
	localparam int unsigned EXC_IDX_W   = 6;
	localparam int unsigned SPEED_W     = 16;
	localparam int unsigned CNT_W       = 7;
	localparam int unsigned GCNT_W      = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic signed [SPEED_W-1:0] THRESH_RESET = 16'sd1280;

	localparam logic [1:0] MODE_RAISE   = 2'd0;
	localparam logic [1:0] MODE_SOLVE   = 2'd1;
	localparam logic [1:0] MODE_QUERY   = 2'd2;
	localparam logic [1:0] MODE_RELEASE = 2'd3;

	typedef enum logic [2:0] {
		OP_RAISE,
		OP_SOLVE,
		OP_QUERY,
		OP_RELEASE,
		OP_ERROR,
		OP_SKIP
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [NODE_IDX_W-1:0] node;
		logic [EXC_IDX_W-1:0]  exc;
		logic                  slow;
	} cmd_t;

endpackage

>>> design/efa_front.sv
module efa_front #(
	parameter int unsigned NODE_COUNT = 16,
	parameter int unsigned FLAG_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [efa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic [efa_pkg::IN_USER_W-1:0]   s_axis_tuser,
	input  logic                            cfg_we,
	input  logic [efa_pkg::SPEED_W-1:0]     cfg_wdata,
	output logic                            push_valid,
	input  logic                            push_ready,
	output efa_pkg::cmd_t                   push_cmd
);

	localparam int unsigned FLAG_W = FLAG_BYTES * 8;

	logic signed [efa_pkg::SPEED_W-1:0] thresh_q;
	logic                               valid_s1;
	efa_pkg::cmd_t                      cmd_s1;
	efa_pkg::cmd_t                      cmd_in;
	logic [efa_pkg::NODE_IDX_W-1:0]     node;
	logic [efa_pkg::EXC_IN_W-1:0]       exc;
	logic signed [efa_pkg::SPEED_W-1:0] speed;
	logic                               node_ok;
	logic                               exc_ok;

	assign node  = s_axis_tdata[3:0];
	assign exc   = s_axis_tdata[11:4];
	assign speed = s_axis_tdata[27:12];

	assign node_ok = {3'b000, node} < 7'(NODE_COUNT);
	assign exc_ok  = exc < 8'(FLAG_W);

	always_comb begin
		cmd_in.node = node;
		cmd_in.exc  = exc[efa_pkg::EXC_IDX_W-1:0];
		cmd_in.slow = speed < thresh_q;
		cmd_in.op   = efa_pkg::OP_QUERY;
		if (!node_ok) begin
			cmd_in.op = efa_pkg::OP_SKIP;
		end else begin
			unique case (s_axis_tuser)
				efa_pkg::MODE_RAISE:   cmd_in.op = exc_ok ? efa_pkg::OP_RAISE : efa_pkg::OP_ERROR;
				efa_pkg::MODE_SOLVE:   cmd_in.op = exc_ok ? efa_pkg::OP_SOLVE : efa_pkg::OP_ERROR;
				efa_pkg::MODE_QUERY:   cmd_in.op = efa_pkg::OP_QUERY;
				efa_pkg::MODE_RELEASE: cmd_in.op = efa_pkg::OP_RELEASE;
			endcase
		end
	end

	assign s_axis_tready = !valid_s1 || push_ready;
	assign push_valid    = valid_s1;
	assign push_cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= efa_pkg::THRESH_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

>>> design/efa_queue.sv
module efa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  efa_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output efa_pkg::cmd_t pop_cmd
);

	localparam int unsigned PTR_W = (efa_pkg::QUEUE_DEPTH > 1) ? $clog2(efa_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(efa_pkg::QUEUE_DEPTH + 1);

	efa_pkg::cmd_t    slots_q [efa_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign push_ready = fill_q != FILL_W'(efa_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(efa_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(efa_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> design/efa_back.sv
`include "emergency_flag_aggregator_assert.svh"

module efa_back #(
	parameter int unsigned NODE_COUNT = 16,
	parameter int unsigned FLAG_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  efa_pkg::cmd_t                  q_cmd,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [efa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int unsigned FLAG_W = FLAG_BYTES * 8;
	localparam int unsigned NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int unsigned EXC_W  = $clog2(FLAG_W);

	logic [FLAG_W-1:0]              maps_q [NODE_COUNT];
	logic [efa_pkg::CNT_W-1:0]      cnts_q [NODE_COUNT];
	logic [efa_pkg::GCNT_W-1:0]     gc_q;
	logic                           line_q;
	logic                           out_valid_q;
	logic [efa_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                           fire;
	logic [NODE_W-1:0]              idx;
	logic [EXC_W-1:0]               exc_sel;
	logic [FLAG_W-1:0]              mask;
	logic [FLAG_W-1:0]              cur_map;
	logic [efa_pkg::CNT_W-1:0]      cur_cnt;
	logic                           hit;
	logic                           wr;
	logic [FLAG_W-1:0]              nxt_map;
	logic [efa_pkg::CNT_W-1:0]      nxt_cnt;
	logic [efa_pkg::GCNT_W-1:0]     nxt_gc;
	logic [efa_pkg::GCNT_W-1:0]     gc_dec;
	logic                           nxt_line;
	logic                           node_active;
	logic                           any_active;
	logic                           err;
	logic                           cnt_map_bad;
	logic                           err_fire;

	assign fire    = q_valid && (!out_valid_q || m_axis_tready);
	assign q_ready = fire;
	assign idx     = NODE_W'(q_cmd.node);
	assign exc_sel = EXC_W'(q_cmd.exc);
	assign mask    = FLAG_W'(1) << exc_sel;
	assign cur_map = maps_q[idx];
	assign cur_cnt = cnts_q[idx];
	assign hit     = |(cur_map & mask);
	assign gc_dec  = gc_q - efa_pkg::GCNT_W'(1);

	always_comb begin
		nxt_map  = cur_map;
		nxt_cnt  = cur_cnt;
		nxt_gc   = gc_q;
		nxt_line = line_q;
		wr       = 1'b0;
		unique case (q_cmd.op)
			efa_pkg::OP_RAISE: begin
				if (!hit) begin
					wr      = 1'b1;
					nxt_map = cur_map | mask;
					nxt_cnt = cur_cnt + efa_pkg::CNT_W'(1);
					if (cur_cnt == '0) begin
						nxt_gc = gc_q + efa_pkg::GCNT_W'(1);
					end
				end
				if (q_cmd.slow) begin
					nxt_line = 1'b0;
				end
			end
			efa_pkg::OP_SOLVE: begin
				if (hit) begin
					wr      = 1'b1;
					nxt_map = cur_map & ~mask;
					nxt_cnt = cur_cnt - efa_pkg::CNT_W'(1);
					if (cur_cnt == efa_pkg::CNT_W'(1)) begin
						nxt_gc = gc_dec;
						if (gc_dec == '0) begin
							nxt_line = 1'b1;
						end
					end
				end
			end
			efa_pkg::OP_RELEASE: begin
				wr      = 1'b1;
				nxt_map = '0;
				nxt_cnt = '0;
				if (cur_cnt != '0) begin
					nxt_gc = gc_dec;
					if (gc_dec == '0) begin
						nxt_line = 1'b1;
					end
				end
			end
			efa_pkg::OP_QUERY, efa_pkg::OP_ERROR, efa_pkg::OP_SKIP: begin
			end
			default: begin
			end
		endcase
		err         = q_cmd.op == efa_pkg::OP_ERROR;
		node_active = (q_cmd.op != efa_pkg::OP_SKIP) && (nxt_cnt != '0);
		any_active  = node_active || (nxt_gc != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				maps_q[i] <= '0;
				cnts_q[i] <= '0;
			end
			gc_q        <= '0;
			line_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (wr) begin
					maps_q[idx] <= nxt_map;
					cnts_q[idx] <= nxt_cnt;
				end
				gc_q   <= nxt_gc;
				line_q <= nxt_line;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {4'b0000, nxt_gc, nxt_line, any_active, node_active, err};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign cnt_map_bad = q_valid && (q_cmd.op != efa_pkg::OP_SKIP)
		&& ((cur_cnt == '0) != (cur_map == '0));
	assign err_fire    = fire && (q_cmd.op == efa_pkg::OP_ERROR);

	`EFA_NEVER(a_line_low_needs_active, !line_q && (gc_q == '0), "line low with no active node")
	`EFA_NEVER(a_cnt_map_agree, cnt_map_bad, "node count disagrees with flag map")
	`EFA_ASSERT(a_error_keeps_state, err_fire |=> $stable(gc_q) && $stable(line_q), "error changed state")
	`EFA_ASSERT(a_no_overwrite, out_valid_q && !m_axis_tready |-> !fire, "result overwritten")

endmodule

>>> design/emergency_flag_aggregator.sv
// Channel  | Handshake                     | Payload
// s_axis   | s_axis_tvalid / s_axis_tready | tuser: mode; tdata: node, exception, speed
// m_axis   | m_axis_tvalid / m_axis_tready | tdata: status flags and active node count
// cfg      | cfg_we                        | cfg_wdata: speed threshold, Q8.8
//
// Sustained rate is one transaction per cycle while m_axis accepts, set by the flag table
// read-modify-write in the back end. Results pass the front, queue and result registers.
// Reset clears all flag maps and counts at once, sets the line high and the threshold to 5.0.
// A stalled m_axis fills the result register, then the two-entry queue, then the front
// register, and only then drops s_axis_tready.
module emergency_flag_aggregator #(
	parameter int unsigned NODE_COUNT = 16,
	parameter int unsigned FLAG_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// node_index[3:0], exception_index[11:4], speed[27:12], zero fill
	input  logic [efa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// mode[1:0]
	input  logic [efa_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// error[0], node_active[1], any_active[2], shutdown_line[3], active_nodes[11:4], zero fill
	output logic [efa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [efa_pkg::SPEED_W-1:0]     cfg_wdata
);

	logic          push_valid;
	logic          push_ready;
	efa_pkg::cmd_t push_cmd;
	logic          q_valid;
	logic          q_ready;
	efa_pkg::cmd_t q_cmd;

	efa_front #(
		.NODE_COUNT(NODE_COUNT),
		.FLAG_BYTES(FLAG_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	efa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_cmd   (q_cmd)
	);

	efa_back #(
		.NODE_COUNT(NODE_COUNT),
		.FLAG_BYTES(FLAG_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_cmd        (q_cmd),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

>>> tb/sv/emergency_flag_aggregator_tb.sv
`timescale 1ns / 1ps

module emergency_flag_aggregator_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_LEN    = 80;

	typedef struct packed {
		logic [7:0] count;
		logic       line;
		logic       any_act;
		logic       node_act;
		logic       err;
	} status_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [efa_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [efa_pkg::IN_USER_W-1:0]  s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [efa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           cfg_we;
	logic [efa_pkg::SPEED_W-1:0]    cfg_wdata;

	logic [63:0]                        flag_map [16];
	logic [6:0]                         set_count [16];
	logic [7:0]                         active_count;
	logic                               line_ok;
	logic signed [efa_pkg::SPEED_W-1:0] speed_limit;

	status_t pending_status [$];

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned events_sent;
	int unsigned status_checked;
	int unsigned input_stall_cycles;
	int unsigned limit_writes;
	int unsigned line_drops;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned hold_left;

	emergency_flag_aggregator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_status.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void drop_active_node();
		active_count = active_count - 8'd1;
		if (active_count == 8'd0)
			line_ok = 1'b1;
	endfunction

	function automatic status_t predict_status(input logic [1:0] mode, input logic [3:0] node,
		input logic [7:0] exc, input logic signed [15:0] speed);
		status_t     s;
		logic [63:0] bit_mask;
		s = '0;
		if (mode == efa_pkg::MODE_RAISE || mode == efa_pkg::MODE_SOLVE) begin
			if (exc >= 8'd64) begin
				s.err = 1'b1;
			end else begin
				bit_mask = 64'd1 << exc[5:0];
				if (mode == efa_pkg::MODE_RAISE) begin
					if ((flag_map[node] & bit_mask) == 64'd0) begin
						flag_map[node] = flag_map[node] | bit_mask;
						if (set_count[node] == '0)
							active_count = active_count + 8'd1;
						set_count[node] = set_count[node] + 7'd1;
					end
					if (speed < speed_limit) begin
						if (line_ok)
							line_drops++;
						line_ok = 1'b0;
					end
				end else if ((flag_map[node] & bit_mask) != 64'd0) begin
					flag_map[node] = flag_map[node] & ~bit_mask;
					set_count[node] = set_count[node] - 7'd1;
					if (set_count[node] == '0)
						drop_active_node();
				end
			end
		end else if (mode == efa_pkg::MODE_RELEASE) begin
			if (set_count[node] != '0)
				drop_active_node();
			flag_map[node] = 64'd0;
			set_count[node] = '0;
		end
		s.node_act = set_count[node] != '0;
		s.any_act = set_count[node] != '0 || active_count != 8'd0;
		s.line = line_ok;
		s.count = active_count;
		return s;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_val,
		input int unsigned got_val);
		mismatch_count++;
		$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
	endtask

	always @(posedge clk) begin
		status_t exp_s;
		status_t got_s;
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			input_stall_cycles++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_s = status_t'(m_axis_tdata[11:0]);
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected result", 0, m_axis_tdata);
			end else begin
				exp_s = pending_status.pop_front();
				status_checked++;
				if (got_s.err != exp_s.err)
					report_mismatch("error", exp_s.err, got_s.err);
				if (got_s.node_act != exp_s.node_act)
					report_mismatch("node_active", exp_s.node_act, got_s.node_act);
				if (got_s.any_act != exp_s.any_act)
					report_mismatch("any_active", exp_s.any_act, got_s.any_act);
				if (got_s.line != exp_s.line)
					report_mismatch("shutdown_line", exp_s.line, got_s.line);
				if (got_s.count != exp_s.count)
					report_mismatch("active_nodes", exp_s.count, got_s.count);
				if (m_axis_tdata[efa_pkg::OUT_DATA_W-1:12] != '0)
					report_mismatch("tdata fill", 0, m_axis_tdata[efa_pkg::OUT_DATA_W-1:12]);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else begin
			m_axis_tready = $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic send_event(input logic [1:0] mode, input logic [3:0] node,
		input logic [7:0] exc, input logic signed [15:0] speed);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		s_axis_tuser = mode;
		s_axis_tdata = {4'd0, speed, exc, node};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_status.push_back(predict_status(mode, node, exc, speed));
		events_sent++;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_speed_limit(input logic signed [15:0] value);
		wait_idle();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		speed_limit = value;
		limit_writes++;
	endtask

	task automatic send_random_event();
		logic [1:0]         mode;
		logic [3:0]         node;
		logic [7:0]         exc;
		logic signed [15:0] speed;
		int unsigned        pick;
		pick = $urandom_range(99);
		if (pick < 38)
			mode = efa_pkg::MODE_RAISE;
		else if (pick < 72)
			mode = efa_pkg::MODE_SOLVE;
		else if (pick < 82)
			mode = efa_pkg::MODE_QUERY;
		else
			mode = efa_pkg::MODE_RELEASE;
		node = ($urandom_range(99) < 75) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 6)
			exc = 8'($urandom_range(255, 64));
		else if (pick < 76)
			exc = 8'($urandom_range(7));
		else
			exc = 8'($urandom_range(63));
		if ($urandom_range(1))
			speed = speed_limit + 16'($urandom_range(511)) - 16'sd256;
		else
			speed = 16'($urandom_range(65535));
		send_event(mode, node, exc, speed);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_event(efa_pkg::MODE_QUERY, 4'd0, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_RAISE, 4'd0, 8'd0, 16'sd32767);
		send_event(efa_pkg::MODE_RAISE, 4'd0, 8'd0, -16'sd32768);
		send_event(efa_pkg::MODE_RAISE, 4'd15, 8'd63, 16'sd1280);
		send_event(efa_pkg::MODE_RAISE, 4'd5, 8'd64, -16'sd32768);
		send_event(efa_pkg::MODE_SOLVE, 4'd5, 8'd255, 16'sd0);
		send_event(efa_pkg::MODE_SOLVE, 4'd0, 8'd1, 16'sd0);
		send_event(efa_pkg::MODE_SOLVE, 4'd0, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_QUERY, 4'd15, 8'd255, -16'sd1);
		send_event(efa_pkg::MODE_RELEASE, 4'd3, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_RELEASE, 4'd15, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_RAISE, 4'd10, 8'd42, 16'sd1279);
		send_event(efa_pkg::MODE_RAISE, 4'd10, 8'd21, 16'h5555);
		send_event(efa_pkg::MODE_RAISE, 4'd9, 8'd0, 16'hAAAA);
		send_event(efa_pkg::MODE_QUERY, 4'd9, 8'd200, 16'sd0);
		send_event(efa_pkg::MODE_RELEASE, 4'd10, 8'hAA, 16'hAAAA);
		send_event(efa_pkg::MODE_QUERY, 4'd10, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_SOLVE, 4'd9, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_QUERY, 4'd9, 8'd0, 16'sd0);
	endtask

	task automatic test_threshold_extremes();
		set_speed_limit(-16'sd32768);
		send_event(efa_pkg::MODE_RAISE, 4'd1, 8'd7, -16'sd32768);
		send_event(efa_pkg::MODE_RAISE, 4'd2, 8'd33, 16'sd0);
		send_event(efa_pkg::MODE_RELEASE, 4'd1, 8'd0, 16'sd0);
		send_event(efa_pkg::MODE_SOLVE, 4'd2, 8'd33, 16'sd0);
		set_speed_limit(16'sd32767);
		send_event(efa_pkg::MODE_RAISE, 4'd4, 8'd12, 16'sd32767);
		send_event(efa_pkg::MODE_RAISE, 4'd4, 8'd13, 16'sd32766);
		send_event(efa_pkg::MODE_SOLVE, 4'd4, 8'd12, 16'sd0);
		send_event(efa_pkg::MODE_SOLVE, 4'd4, 8'd13, 16'sd0);
		set_speed_limit(16'sd0);
		send_event(efa_pkg::MODE_RAISE, 4'd6, 8'd1, -16'sd1);
		send_event(efa_pkg::MODE_RELEASE, 4'd6, 8'd0, 16'sd0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_speed_limit(efa_pkg::THRESH_RESET);
		@(negedge clk);
		hold_req++;
		repeat (60) send_random_event();
	endtask

	task automatic test_random(input int unsigned count, input int unsigned idle_pct,
		input int unsigned stall_pct, input logic signed [15:0] limit);
		set_speed_limit(limit);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_event();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		for (int i = 0; i < 16; i++) begin
			flag_map[i] = 64'd0;
			set_count[i] = '0;
		end
		active_count = '0;
		line_ok = 1'b1;
		speed_limit = efa_pkg::THRESH_RESET;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_threshold_extremes();
		test_backpressure();
		test_random(420, 0, 0, 16'($urandom_range(65535)));
		test_random(420, 47, 0, efa_pkg::THRESH_RESET);
		test_random(420, 0, 47, 16'($urandom_range(65535)));
		test_random(420, 35, 35, -16'sd32768);
		set_speed_limit(16'sd32767);
		test_random(60, 35, 35, 16'sd32767);

		wait_idle();
		if (pending_status.size() != 0)
			report_mismatch("results left over", 0, pending_status.size());
		$display("%0d transactions sent, %0d results checked, %0d threshold writes",
			events_sent, status_checked, limit_writes);
		$display("line pulled low %0d times, input stalled for %0d cycles",
			line_drops, input_stall_cycles);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
